>>> rtl/cmbgen_pkg.sv
// Shared constants and types of the combination sequence generator.
`default_nettype none

package cmbgen_pkg;

  localparam int MAX_SET_DEF = 32;
  localparam int CFG_W       = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int OUT_W       = 32;

  localparam logic [CFG_W-1:0] SET_SIZE_RST     = 6'd4;
  localparam logic [CFG_W-1:0] CHOOSE_COUNT_RST = 6'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_COUNT = 4'd1;

  typedef struct packed {
    logic [CFG_W-1:0] n_eff;  // set size, saturated to MAX_SET
    logic [CFG_W-1:0] r;      // choose count
    logic             wr;     // a register write lands this cycle
  } cfg_state_t;

endpackage

`default_nettype wire

>>> rtl/cmbgen_if.sv
// Channel interfaces: restart requests, subset results and register writes.
`default_nettype none

interface cmbgen_in_if import cmbgen_pkg::*;;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cmbgen_out_if import cmbgen_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] members_mask;
  logic             subset_valid;
  logic             final_subset;
  logic [OUT_W-1:0] ordinal;
  modport source (output valid, output members_mask, output subset_valid,
                  output final_subset, output ordinal, input ready);
  modport sink   (input valid, input members_mask, input subset_valid,
                  input final_subset, input ordinal, output ready);
endinterface

interface cmbgen_cfg_if import cmbgen_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/cmbgen_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none

module cmbgen_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/cmbgen_cfg.sv
// Configuration registers: set size and choose count.
`default_nettype none

module cmbgen_cfg import cmbgen_pkg::*; #(
  parameter int MAX_SET = MAX_SET_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cmbgen_cfg_if.sink  cfg_ch,
  output cfg_state_t  cfg_state
);

  logic [CFG_W-1:0] set_size_r;
  logic [CFG_W-1:0] choose_count_r;
  logic             beat;
  logic             hit;

  assign cfg_ch.ready = 1'b1;
  assign beat = cfg_ch.valid && cfg_ch.ready;
  assign hit  = (cfg_ch.index == REG_SET_SIZE) || (cfg_ch.index == REG_CHOOSE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r     <= SET_SIZE_RST;
      choose_count_r <= CHOOSE_COUNT_RST;
    end else if (beat) begin
      unique case (cfg_ch.index)
        REG_SET_SIZE:     set_size_r     <= cfg_ch.data;
        REG_CHOOSE_COUNT: choose_count_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_state.n_eff = set_size_r;
    if (int'(set_size_r) > MAX_SET) begin
      cfg_state.n_eff = CFG_W'(MAX_SET);
    end
    cfg_state.r  = choose_count_r;
    cfg_state.wr = beat && hit;
  end

endmodule

`default_nettype wire

>>> rtl/cmbgen_seq.sv
// Sequencer and shared compare/increment unit that steps the combination.
`default_nettype none

module cmbgen_seq import cmbgen_pkg::*; #(
  parameter int MAX_SET = MAX_SET_DEF,
  localparam int POS_W  = $clog2(MAX_SET)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_state_t        cfg_state,
  cmbgen_in_if.sink              in_ch,
  cmbgen_out_if.source           out_ch,
  output logic                   ram_we,
  output logic       [POS_W-1:0] ram_waddr,
  output logic       [POS_W-1:0] ram_wdata,
  output logic       [POS_W-1:0] ram_raddr,
  input  wire logic  [POS_W-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SNAP, S_RD, S_CMP, S_FILL, S_EMIT
  } state_t;

  state_t             state_r;
  logic               loaded_r;
  logic               exhausted_r;
  logic [OUT_W-1:0]   count_r;
  logic [MAX_SET-1:0] mask_r;
  logic [POS_W-1:0]   i_r;
  logic [POS_W-1:0]   k_r;
  logic [POS_W-1:0]   val_r;
  logic [OUT_W-1:0]   res_mask_r;
  logic [OUT_W-1:0]   res_ord_r;
  logic               res_valid_r;
  logic               res_final_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_mask_r;
  logic [OUT_W-1:0]   out_ord_r;
  logic               out_sv_r;
  logic               out_final_r;

  logic               empty;
  logic [POS_W-1:0]   r_last;
  logic [CFG_W-1:0]   target;
  logic               at_max;
  logic [POS_W-1:0]   bump;

  function automatic logic [MAX_SET-1:0] onehot(input logic [POS_W-1:0] idx);
    logic [MAX_SET-1:0] one;
    one = {{(MAX_SET-1){1'b0}}, 1'b1};
    return one << idx;
  endfunction

  assign empty  = (cfg_state.r == '0) || (cfg_state.r > cfg_state.n_eff);
  assign r_last = POS_W'(cfg_state.r - 1'b1);
  // highest value position i may hold: n - r + i
  assign target = cfg_state.n_eff - cfg_state.r + CFG_W'(i_r);
  assign at_max = (CFG_W'(ram_rdata) == target);
  assign bump   = ram_rdata + 1'b1;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.members_mask = out_mask_r;
  assign out_ch.ordinal      = out_ord_r;
  assign out_ch.subset_valid = out_sv_r;
  assign out_ch.final_subset = out_final_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_r;
    ram_wdata = k_r;
    ram_raddr = i_r;
    unique case (state_r)
      S_LOAD: ram_we = 1'b1;
      S_CMP: begin
        ram_we    = !at_max;
        ram_waddr = i_r;
        ram_wdata = bump;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = val_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= 1'b0;
      exhausted_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_state.wr) begin
        loaded_r <= 1'b0;
      end else if (in_ch.valid && in_ch.ready && (in_ch.restart || !loaded_r)) begin
        loaded_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.restart || !loaded_r) begin
              count_r  <= '0;
              if (empty) begin
                exhausted_r <= 1'b1;
                res_valid_r <= 1'b0;
                state_r     <= S_EMIT;
              end else begin
                exhausted_r <= 1'b0;
                mask_r      <= '0;
                k_r         <= '0;
                state_r     <= S_LOAD;
              end
            end else if (exhausted_r) begin
              res_valid_r <= 1'b0;
              state_r     <= S_EMIT;
            end else begin
              state_r <= S_SNAP;
            end
          end
        end
        S_LOAD: begin
          mask_r <= mask_r | onehot(k_r);
          k_r    <= k_r + 1'b1;
          if (k_r == r_last) begin
            state_r <= S_SNAP;
          end
        end
        S_SNAP: begin
          res_mask_r  <= OUT_W'(mask_r);
          res_ord_r   <= count_r;
          res_valid_r <= 1'b1;
          i_r         <= r_last;
          state_r     <= S_RD;
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (at_max) begin
            // top-packed entry: drop its bit, refilled later
            mask_r <= mask_r & ~onehot(ram_rdata);
            if (i_r == '0) begin
              res_final_r <= 1'b1;
              exhausted_r <= 1'b1;
              state_r     <= S_EMIT;
            end else begin
              i_r     <= i_r - 1'b1;
              state_r <= S_RD;
            end
          end else begin
            mask_r      <= (mask_r & ~onehot(ram_rdata)) | onehot(bump);
            count_r     <= count_r + 1'b1;
            res_final_r <= 1'b0;
            if (i_r == r_last) begin
              state_r <= S_EMIT;
            end else begin
              k_r     <= i_r + 1'b1;
              val_r   <= bump + 1'b1;
              state_r <= S_FILL;
            end
          end
        end
        S_FILL: begin
          mask_r <= mask_r | onehot(val_r);
          k_r    <= k_r + 1'b1;
          val_r  <= val_r + 1'b1;
          if (k_r == r_last) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_sv_r    <= res_valid_r;
            out_mask_r  <= res_valid_r ? res_mask_r : '0;
            out_ord_r   <= res_valid_r ? res_ord_r : '0;
            out_final_r <= res_valid_r && res_final_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/combination_sequence_generator.sv
// Top level of the lexicographic combination sequence generator.
`default_nettype none

// Each in_ beat yields one out_ beat: the current r-of-n subset as a bit mask,
// its ordinal and a last-subset flag, then the state steps to the next subset.
// A restart beat (or the first beat after reset or a register write) reloads
// 0..r-1 first. Items are taken one at a time. A beat passes through an
// accepting state, a reload of the r positions when restarting, a snapshot,
// a read and a compare per position examined in the right-to-left scan, a
// refill of each position right of the one raised, then output, which waits
// while the output register stays full. A reload leaves only the rightmost
// position to raise unless r equals n. Positions are kept in a RAM with one
// write port and a registered read. An empty or exhausted sequence goes from
// acceptance straight to output without a scan. A finished result waits in
// the output register while the next beat is taken.

module combination_sequence_generator import cmbgen_pkg::*; #(
  parameter int MAX_SET = MAX_SET_DEF,
  localparam int POS_W  = $clog2(MAX_SET)
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  cmbgen_in_if.sink     in_chan,
  cmbgen_out_if.source  out_chan,
  cmbgen_cfg_if.sink    cfg_chan
);

  cfg_state_t       cfg_state;
  logic             ram_we;
  logic [POS_W-1:0] ram_waddr;
  logic [POS_W-1:0] ram_wdata;
  logic [POS_W-1:0] ram_raddr;
  logic [POS_W-1:0] ram_rdata;

  cmbgen_cfg #(.MAX_SET(MAX_SET)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_chan),
    .cfg_state (cfg_state)
  );

  cmbgen_ram #(.WIDTH(POS_W), .DEPTH(MAX_SET)) u_pos_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  cmbgen_seq #(.MAX_SET(MAX_SET)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_state (cfg_state),
    .in_ch     (in_chan),
    .out_ch    (out_chan),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // an empty result carries no mask, ordinal or last flag
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.subset_valid |->
      out_chan.members_mask == '0 && out_chan.ordinal == '0 && !out_chan.final_subset)
    else $error("empty result carries payload");

  // the input is not ready again directly after a taken beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken twice in a row");

  a_final_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.final_subset |-> out_chan.subset_valid)
    else $error("last flag on empty result");

endmodule

`default_nettype wire
